[rtl/core/bmf_pkg.sv]
// bmf_pkg: shared constants, codes and word types of the first-free bitmap allocator
// used by bmf_ctrl, bmf_datapath and bitmap_first_free_allocator; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bmf_pkg;

  localparam int NUM_ITEMS = 1024;
  localparam int WORD_BITS = 32;
  localparam int MAP_WORDS = (NUM_ITEMS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int INDEX_W   = 10;
  localparam int COUNT_W   = 11;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(NUM_ITEMS);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_SET   = 3'd2,
    OP_CLEAR = 3'd3,
    OP_GET   = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_RANGE       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CTL_IDLE   = 2'd0,
    CTL_SCAN   = 2'd1,
    CTL_ACCESS = 2'd2
  } ctl_state_e;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] item_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  result_index;
    logic                bit_value;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_alloc;
    logic hit;
    logic last;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/bmf_ctrl.sv]
// bmf_ctrl: sequencing state machine of the allocator
// depends on bmf_pkg for state codes and command / status structs
`timescale 1ns / 1ps
`default_nettype none

module bmf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bmf_pkg::dp_stat_t stat_i,
  output bmf_pkg::dp_cmd_t  cmd_o,
  output logic              busy_o
);

  bmf_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmf_pkg::CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bmf_pkg::CTL_IDLE: begin
        if (start_i) begin
          state_d = stat_i.req_alloc ? bmf_pkg::CTL_SCAN : bmf_pkg::CTL_ACCESS;
        end
      end
      bmf_pkg::CTL_SCAN: begin
        if (stat_i.hit || stat_i.last) begin
          state_d = bmf_pkg::CTL_IDLE;
        end
      end
      bmf_pkg::CTL_ACCESS: begin
        state_d = bmf_pkg::CTL_IDLE;
      end
      default: begin
        state_d = bmf_pkg::CTL_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      bmf_pkg::CTL_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      bmf_pkg::CTL_SCAN: begin
        cmd_o.scan   = 1'b1;
        cmd_o.finish = stat_i.hit || stat_i.last;
      end
      bmf_pkg::CTL_ACCESS: begin
        cmd_o.finish = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/bmf_datapath.sv]
// bmf_datapath: bitmap word memory, count register, word scan logic and result register
// depends on bmf_pkg; driven by bmf_ctrl through dp_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module bmf_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bmf_pkg::dp_cmd_t                      cmd_i,
  output bmf_pkg::dp_stat_t                     stat_o,
  input  bmf_pkg::req_t                         req_i,
  input  logic                                  cfg_we_i,
  input  logic [bmf_pkg::COUNT_W-1:0]           cfg_data_i,
  output logic                                  done_o,
  output bmf_pkg::rsp_t                         rsp_o
);

  localparam int WB = bmf_pkg::WORD_BITS;
  localparam int WW = bmf_pkg::WORD_W;
  localparam int BW = bmf_pkg::BIT_W;
  localparam int CW = bmf_pkg::COUNT_W;

  // lowest set bit
  function automatic logic [BW-1:0] first_one(input logic [WB-1:0] v);
    logic [BW-1:0] r;
    r = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (v[i]) r = BW'(i);
    end
    return r;
  endfunction

  // bits of a word that sit below the managed count
  function automatic logic [WB-1:0] limit_mask(input logic [WW-1:0] w,
                                               input logic [CW-1:0] cnt);
    logic [CW-1:0] base;
    logic [CW-1:0] diff;
    logic [WB-1:0] m;
    base = CW'({w, {BW{1'b0}}});
    diff = cnt - base;
    if (cnt <= base) begin
      m = '0;
    end else if (diff >= CW'(WB)) begin
      m = '1;
    end else begin
      m = ~({WB{1'b1}} << diff[BW-1:0]);
    end
    return m;
  endfunction

  logic [WB-1:0]     mem_q [bmf_pkg::MAP_WORDS];
  logic [bmf_pkg::MAP_WORDS-1:0] valid_q;
  logic [WB-1:0]     rdata_q;
  logic              rvalid_q;
  logic [CW-1:0]     count_q;
  bmf_pkg::req_t     req_q;
  logic [WW-1:0]     rd_ptr_q, chk_ptr_q;
  logic              done_q;
  bmf_pkg::rsp_t     rsp_q, rsp_d;

  logic              rd_en;
  logic [WW-1:0]     rd_addr;
  logic              we;
  logic [WB-1:0]     wdata;
  logic [CW-1:0]     cnt_eff;
  logic [WB-1:0]     word_v;
  logic [WB-1:0]     free_bits;
  logic [BW-1:0]     first_bit;
  logic [CW-1:0]     next_base;
  logic [BW-1:0]     bit_sel;
  logic              cur_bit;
  logic              in_range;

  assign cnt_eff = (count_q > bmf_pkg::COUNT_MAX) ? bmf_pkg::COUNT_MAX : count_q;

  assign rd_en   = cmd_i.load || cmd_i.scan;
  assign rd_addr = cmd_i.scan ? rd_ptr_q :
                   (bmf_pkg::op_e'(req_i.op) == bmf_pkg::OP_ALLOC) ? '0 :
                   req_i.item_index[bmf_pkg::INDEX_W-1 -: WW];

  assign word_v    = rvalid_q ? rdata_q : '0;
  assign free_bits = ~word_v & limit_mask(chk_ptr_q, cnt_eff);
  assign first_bit = first_one(free_bits);
  assign next_base = CW'({1'b0, chk_ptr_q} + (WW + 1)'(1)) << BW;
  assign bit_sel   = req_q.item_index[BW-1:0];
  assign cur_bit   = word_v[bit_sel];
  assign in_range  = CW'(req_q.item_index) < cnt_eff;

  assign stat_o.req_alloc = (bmf_pkg::op_e'(req_i.op) == bmf_pkg::OP_ALLOC);
  assign stat_o.hit       = |free_bits;
  assign stat_o.last      = next_base >= cnt_eff;

  // result and write-back of the word under check
  always_comb begin
    we                 = 1'b0;
    wdata              = word_v;
    rsp_d.status       = bmf_pkg::ST_OK;
    rsp_d.result_index = req_q.item_index;
    rsp_d.bit_value    = 1'b0;
    case (bmf_pkg::op_e'(req_q.op))
      bmf_pkg::OP_ALLOC: begin
        if (|free_bits) begin
          we                 = cmd_i.finish;
          wdata              = word_v | (WB'(1) << first_bit);
          rsp_d.result_index = {chk_ptr_q, first_bit};
        end else begin
          rsp_d.status       = bmf_pkg::ST_FULL;
          rsp_d.result_index = '0;
        end
      end
      bmf_pkg::OP_FREE: begin
        if (!in_range) begin
          rsp_d.status = bmf_pkg::ST_RANGE;
        end else if (!cur_bit) begin
          rsp_d.status = bmf_pkg::ST_DOUBLE_FREE;
        end else begin
          we    = cmd_i.finish;
          wdata = word_v & ~(WB'(1) << bit_sel);
        end
      end
      bmf_pkg::OP_SET: begin
        if (!in_range) begin
          rsp_d.status = bmf_pkg::ST_RANGE;
        end else begin
          we    = cmd_i.finish;
          wdata = word_v | (WB'(1) << bit_sel);
        end
      end
      bmf_pkg::OP_CLEAR: begin
        if (!in_range) begin
          rsp_d.status = bmf_pkg::ST_RANGE;
        end else begin
          we    = cmd_i.finish;
          wdata = word_v & ~(WB'(1) << bit_sel);
        end
      end
      bmf_pkg::OP_GET: begin
        if (!in_range) begin
          rsp_d.status = bmf_pkg::ST_RANGE;
        end else begin
          rsp_d.bit_value = cur_bit;
        end
      end
      default: begin
        rsp_d.status = bmf_pkg::ST_OK;
      end
    endcase
  end

  // word memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[chk_ptr_q] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.finish) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rvalid_q  <= 1'b0;
      count_q   <= bmf_pkg::COUNT_RESET;
      rd_ptr_q  <= '0;
      chk_ptr_q <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
      if (we) begin
        valid_q[chk_ptr_q] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_q  <= valid_q[rd_addr];
        chk_ptr_q <= rd_addr;
        rd_ptr_q  <= rd_addr + WW'(1);
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

[rtl/core/bitmap_first_free_allocator.sv]
// bitmap_first_free_allocator: top level, first-fit bitmap allocator over 1024 items
// depends on bmf_pkg, bmf_ctrl and bmf_datapath
`timescale 1ns / 1ps
`default_nettype none

// usage
//   command channel: a word on req_i is taken at a clock edge with start high and
//   busy low; ops are alloc, free, set bit, clear bit and get bit
//   result channel: done_o is high for exactly one cycle with the answer on rsp_o;
//   the receiver has no back-pressure and must take it in that cycle
//   config channel: cfg_data_i loads the managed item count when cfg_valid_i and
//   cfg_ready_o are both high; only write it while no command is in flight
// timing
//   free, set, clear, get: busy in the single access state after the accepting edge,
//   done_o in the cycle after that
//   alloc: busy while one bitmap word after another is checked (1 to 32 words), the word
//   reads being streamed from the single read port of the word memory; done_o in
//   the cycle after the last check
//   the next command may be issued in the cycle done_o is high
// reset
//   rst_ni low clears every allocation mark (per-word valid flags, no clearing
//   pass needed) and sets the item count to 1024; the block is ready at once

module bitmap_first_free_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  bmf_pkg::req_t                 req_i,
  // result channel
  output logic                          done_o,
  output bmf_pkg::rsp_t                 rsp_o,
  // item count register
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bmf_pkg::COUNT_W-1:0]   cfg_data_i
);

  bmf_pkg::dp_cmd_t  cmd;
  bmf_pkg::dp_stat_t stat;
  logic              busy_int;

  // sequencer: idle, word scan for alloc, single word access for the rest
  bmf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_int)
  );

  // memory, count register, priority encoder and result register
  bmf_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .req_i     (req_i),
    .cfg_we_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .done_o    (done_o),
    .rsp_o     (rsp_o)
  );

  assign busy        = busy_int;
  // count may only change between commands
  assign cfg_ready_o = !busy_int;

`ifndef NO_ASSERTIONS
  // a result only appears once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // an accepted command always occupies the sequencer
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not start work");

  // an exhausted alloc grants nothing
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == bmf_pkg::ST_FULL)) |-> (rsp_o.result_index == '0))
    else $error("exhausted alloc returned an index");
`endif

endmodule

`default_nettype wire
